[rtl/lr35_pkg.sv]
// shared types and constants of the lr35902 subset executor
`timescale 1ns / 1ps
`default_nettype none
package lr35_pkg;

  typedef enum logic [1:0] {
    KIND_DONE    = 2'd0,
    KIND_READ    = 2'd1,
    KIND_ILLEGAL = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PEND_NONE = 3'd0,
    PEND_LDDE = 3'd1,
    PEND_CPHL = 3'd2,
    PEND_LDH  = 3'd3,
    PEND_POP  = 3'd4,
    PEND_RET  = 3'd5
  } pend_t;

  localparam logic [7:0] FLAG_Z = 8'h80;
  localparam logic [7:0] FLAG_N = 8'h40;
  localparam logic [7:0] FLAG_H = 8'h20;
  localparam logic [7:0] FLAG_C = 8'h10;
  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

endpackage
`default_nettype wire

[rtl/lr35902_instruction_subset_executor.sv]
// top level: boot-rom instruction subset executor with registered result
// result: registered, at the outputs in the cycle after a request is accepted
// throughput: one request per cycle unless the output register holds a stalled result;
// the output register holds a result while stalled
// reset: synchronous active-low rst_n clears all cpu registers and the pending read
`timescale 1ns / 1ps
`default_nettype none
module lr35902_instruction_subset_executor
  import lr35_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [7:0]  in_instr_byte,
  input  wire logic [7:0]  in_imm_low,
  input  wire logic [7:0]  in_imm_high,
  input  wire logic [15:0] in_read_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_mem_address,
  output logic             out_read_wide,
  output logic             out_write_enable,
  output logic             out_write_wide,
  output logic [15:0]      out_write_data,
  output logic [15:0]      out_next_pc,
  output logic [2:0]       out_machine_cycles,
  output logic [7:0]       out_acc_value,
  output logic [7:0]       out_flag_bits
);

  // architectural state
  logic [7:0]  a_r, a_nxt, f_r, f_nxt;
  logic [7:0]  b_r, b_nxt, c_r, c_nxt, d_r, d_nxt, e_r, e_nxt, h_r, h_nxt, l_r, l_nxt;
  logic [15:0] sp_r, sp_nxt, pc_r, pc_nxt;
  pend_t       pend_r, pend_nxt;

  // result register
  logic        vld_r;
  kind_t       kind_r, kind_nxt;
  logic [15:0] addr_r, addr_nxt, wd_r, wd_nxt;
  logic        rw_r, rw_nxt, we_r, we_nxt, ww_r, ww_nxt;
  logic [2:0]  cyc_r, cyc_nxt;

  logic take;
  assign in_stall = vld_r & out_stall;
  assign take     = in_valid & ~in_stall;

  // helper values
  logic [15:0] hl, de, bc, imm16, pc1, pc2, pc3, jr_tgt, spm2;
  logic [7:0]  rl_in, rl_out, cmp_d, sub_res, sub_flags;
  logic        rl_c;
  assign hl     = {h_r, l_r};
  assign de     = {d_r, e_r};
  assign bc     = {b_r, c_r};
  assign imm16  = {in_imm_high, in_imm_low};
  assign pc1    = pc_r + 16'd1;
  assign pc2    = pc_r + 16'd2;
  assign pc3    = pc_r + 16'd3;
  assign jr_tgt = pc2 + {{8{in_imm_low[7]}}, in_imm_low};
  assign spm2   = sp_r - 16'd2;
  assign rl_out = {rl_in[6:0], f_r[4]};
  assign rl_c   = rl_in[7];
  assign sub_res = a_r - b_r;

  // rotate input select
  always_comb begin
    rl_in = a_r;
    if (in_instr_byte == 8'hCB && in_imm_low == 8'h11) rl_in = c_r;
  end

  // compare operand select
  always_comb begin
    cmp_d = b_r;
    if (in_opcode) cmp_d = in_read_data[7:0];
    else if (in_instr_byte == 8'hFE) cmp_d = in_imm_low;
  end

  function automatic logic [7:0] cmp_flags(input logic [7:0] a, input logic [7:0] d);
    cmp_flags = {a == d, 1'b1, a[3:0] < d[3:0], a < d, 4'h0};
  endfunction

  function automatic logic [7:0] inc_flags(input logic [7:0] f, input logic [7:0] r);
    logic [7:0] n;
    n = r + 8'd1;
    inc_flags = {n == 8'd0, 1'b0, r[3:0] == 4'hF, f[4], f[3:0]};
  endfunction

  function automatic logic [7:0] dec_flags(input logic [7:0] f, input logic [7:0] r);
    logic [7:0] n;
    n = r - 8'd1;
    dec_flags = {n == 8'd0, 1'b1, r[3:0] == 4'h0, f[4], f[3:0]};
  endfunction

  // subtract flags share the compare logic
  assign sub_flags = cmp_flags(a_r, cmp_d);

  // execute
  always_comb begin
    a_nxt = a_r; f_nxt = f_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r;
    h_nxt = h_r; l_nxt = l_r; sp_nxt = sp_r; pc_nxt = pc_r; pend_nxt = pend_r;
    kind_nxt = KIND_DONE; addr_nxt = 16'd0; rw_nxt = 1'b0; we_nxt = 1'b0;
    ww_nxt = 1'b0; wd_nxt = 16'd0; cyc_nxt = 3'd0;
    if (in_opcode) begin
      unique case (pend_r)
        PEND_LDDE: begin a_nxt = in_read_data[7:0]; pc_nxt = pc1; cyc_nxt = 3'd2; end
        PEND_CPHL: begin f_nxt = cmp_flags(a_r, cmp_d) | (f_r & 8'h0F);
          pc_nxt = pc1; cyc_nxt = 3'd2; end
        PEND_LDH:  begin a_nxt = in_read_data[7:0]; pc_nxt = pc2; cyc_nxt = 3'd3; end
        PEND_POP:  begin b_nxt = in_read_data[15:8]; c_nxt = in_read_data[7:0];
          sp_nxt = sp_r + 16'd2; pc_nxt = pc1; cyc_nxt = 3'd3; end
        PEND_RET:  begin pc_nxt = in_read_data; sp_nxt = sp_r + 16'd2; cyc_nxt = 3'd4; end
        default:   kind_nxt = KIND_IGNORED;
      endcase
      pend_nxt = PEND_NONE;
    end else if (pend_r != PEND_NONE) begin
      kind_nxt = KIND_IGNORED;
    end else begin
      unique case (in_instr_byte)
        8'h04: begin f_nxt = inc_flags(f_r, b_r); b_nxt = b_r + 8'd1; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h05: begin f_nxt = dec_flags(f_r, b_r); b_nxt = b_r - 8'd1; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h06: begin b_nxt = in_imm_low; pc_nxt = pc2; cyc_nxt = 3'd2; end
        8'h0C: begin f_nxt = inc_flags(f_r, c_r); c_nxt = c_r + 8'd1; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h0D: begin f_nxt = dec_flags(f_r, c_r); c_nxt = c_r - 8'd1; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h0E: begin c_nxt = in_imm_low; pc_nxt = pc2; cyc_nxt = 3'd2; end
        8'h11: begin {d_nxt, e_nxt} = imm16; pc_nxt = pc3; cyc_nxt = 3'd3; end
        8'h13: begin {d_nxt, e_nxt} = de + 16'd1; pc_nxt = pc1; cyc_nxt = 3'd2; end
        8'h15: begin f_nxt = dec_flags(f_r, d_r); d_nxt = d_r - 8'd1; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h16: begin d_nxt = in_imm_low; pc_nxt = pc2; cyc_nxt = 3'd2; end
        8'h17: begin a_nxt = rl_out; f_nxt = {3'b000, rl_c, f_r[3:0]};
          pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h18: begin pc_nxt = jr_tgt; cyc_nxt = 3'd3; end
        8'h1A: begin kind_nxt = KIND_READ; addr_nxt = de; pend_nxt = PEND_LDDE; end
        8'h1D: begin f_nxt = dec_flags(f_r, e_r); e_nxt = e_r - 8'd1; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h1E: begin e_nxt = in_imm_low; pc_nxt = pc2; cyc_nxt = 3'd2; end
        8'h20: begin
          if (!f_r[7]) begin pc_nxt = jr_tgt; cyc_nxt = 3'd3; end
          else begin pc_nxt = pc2; cyc_nxt = 3'd2; end
        end
        8'h21: begin {h_nxt, l_nxt} = imm16; pc_nxt = pc3; cyc_nxt = 3'd3; end
        8'h22: begin we_nxt = 1'b1; addr_nxt = hl; wd_nxt = {8'd0, a_r};
          {h_nxt, l_nxt} = hl + 16'd1; pc_nxt = pc1; cyc_nxt = 3'd2; end
        8'h23: begin {h_nxt, l_nxt} = hl + 16'd1; pc_nxt = pc1; cyc_nxt = 3'd2; end
        8'h24: begin f_nxt = inc_flags(f_r, h_r); h_nxt = h_r + 8'd1; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h28: begin
          if (f_r[7]) begin pc_nxt = jr_tgt; cyc_nxt = 3'd3; end
          else begin pc_nxt = pc2; cyc_nxt = 3'd2; end
        end
        8'h2E: begin l_nxt = in_imm_low; pc_nxt = pc2; cyc_nxt = 3'd2; end
        8'h31: begin sp_nxt = imm16; pc_nxt = pc3; cyc_nxt = 3'd3; end
        8'h32: begin we_nxt = 1'b1; addr_nxt = hl; wd_nxt = {8'd0, a_r};
          {h_nxt, l_nxt} = hl - 16'd1; pc_nxt = pc1; cyc_nxt = 3'd2; end
        8'h3D: begin f_nxt = dec_flags(f_r, a_r); a_nxt = a_r - 8'd1; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h3E: begin a_nxt = in_imm_low; pc_nxt = pc2; cyc_nxt = 3'd2; end
        8'h4F: begin c_nxt = a_r; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h57: begin d_nxt = a_r; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h67: begin h_nxt = a_r; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h77: begin we_nxt = 1'b1; addr_nxt = hl; wd_nxt = {8'd0, a_r}; pc_nxt = pc1; cyc_nxt = 3'd2; end
        8'h7B: begin a_nxt = e_r; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h7C: begin a_nxt = h_r; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'h90: begin a_nxt = sub_res;
          f_nxt = {sub_res == 8'd0, sub_flags[6:4], f_r[3:0]};
          pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'hAF: begin a_nxt = 8'd0; f_nxt = FLAG_Z; pc_nxt = pc1; cyc_nxt = 3'd1; end
        8'hBE: begin kind_nxt = KIND_READ; addr_nxt = hl; pend_nxt = PEND_CPHL; end
        8'hC1: begin kind_nxt = KIND_READ; addr_nxt = sp_r; rw_nxt = 1'b1; pend_nxt = PEND_POP; end
        8'hC5: begin sp_nxt = spm2; we_nxt = 1'b1; ww_nxt = 1'b1; addr_nxt = spm2;
          wd_nxt = bc; pc_nxt = pc1; cyc_nxt = 3'd4; end
        8'hC9: begin kind_nxt = KIND_READ; addr_nxt = sp_r; rw_nxt = 1'b1; pend_nxt = PEND_RET; end
        8'hCB: begin
          // cb prefix: rl c, rl a, bit 7,h
          case (in_imm_low)
            8'h11: begin c_nxt = rl_out; f_nxt = {rl_out == 8'd0, 2'b00, rl_c, f_r[3:0]};
              pc_nxt = pc2; cyc_nxt = 3'd2; end
            8'h17: begin a_nxt = rl_out; f_nxt = {rl_out == 8'd0, 2'b00, rl_c, f_r[3:0]};
              pc_nxt = pc2; cyc_nxt = 3'd2; end
            8'h7C: begin f_nxt = {~h_r[7], 2'b01, f_r[4:0]}; pc_nxt = pc2; cyc_nxt = 3'd2; end
            default: kind_nxt = KIND_ILLEGAL;
          endcase
        end
        8'hCD: begin sp_nxt = spm2; we_nxt = 1'b1; ww_nxt = 1'b1; addr_nxt = spm2;
          wd_nxt = pc3; pc_nxt = imm16; cyc_nxt = 3'd6; end
        8'hE0: begin we_nxt = 1'b1; addr_nxt = HIGH_PAGE | {8'd0, in_imm_low};
          wd_nxt = {8'd0, a_r}; pc_nxt = pc2; cyc_nxt = 3'd3; end
        8'hE2: begin we_nxt = 1'b1; addr_nxt = HIGH_PAGE | {8'd0, c_r};
          wd_nxt = {8'd0, a_r}; pc_nxt = pc1; cyc_nxt = 3'd2; end
        8'hEA: begin we_nxt = 1'b1; addr_nxt = imm16; wd_nxt = {8'd0, a_r};
          pc_nxt = pc3; cyc_nxt = 3'd4; end
        8'hF0: begin kind_nxt = KIND_READ; addr_nxt = HIGH_PAGE | {8'd0, in_imm_low};
          pend_nxt = PEND_LDH; end
        8'hFE: begin f_nxt = cmp_flags(a_r, cmp_d) | (f_r & 8'h0F); pc_nxt = pc2; cyc_nxt = 3'd2; end
        default: kind_nxt = KIND_ILLEGAL;
      endcase
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= 8'd0; f_r <= 8'd0; b_r <= 8'd0; c_r <= 8'd0; d_r <= 8'd0; e_r <= 8'd0;
      h_r <= 8'd0; l_r <= 8'd0; sp_r <= 16'd0; pc_r <= 16'd0; pend_r <= PEND_NONE;
      vld_r <= 1'b0;
    end else begin
      if (take) begin
        a_r <= a_nxt; f_r <= f_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt;
        e_r <= e_nxt; h_r <= h_nxt; l_r <= l_nxt; sp_r <= sp_nxt; pc_r <= pc_nxt;
        pend_r <= pend_nxt;
        vld_r <= 1'b1;
      end else if (!out_stall) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= kind_nxt; addr_r <= addr_nxt; rw_r <= rw_nxt; we_r <= we_nxt;
      ww_r <= ww_nxt; wd_r <= wd_nxt; cyc_r <= cyc_nxt;
    end
  end

  assign out_valid          = vld_r;
  assign out_kind           = kind_r;
  assign out_mem_address    = addr_r;
  assign out_read_wide      = rw_r;
  assign out_write_enable   = we_r;
  assign out_write_wide     = ww_r;
  assign out_write_data     = wd_r;
  assign out_next_pc        = pc_r;
  assign out_machine_cycles = cyc_r;
  assign out_acc_value      = a_r;
  assign out_flag_bits      = f_r;

  // a read request leaves a pending read behind
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && !in_opcode && pend_r == PEND_NONE && kind_nxt == KIND_READ)
      |=> pend_r != PEND_NONE)
    else $error("read request without pending read");

  // completed instructions report nonzero cycles, others report zero
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> ((kind_r == KIND_DONE) == (cyc_r != 3'd0)))
    else $error("cycle count does not match result kind");

  // read, ignored or illegal results leave the program counter alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && kind_nxt != KIND_DONE) |=> $stable(pc_r))
    else $error("pc changed on a result that is not done");

  // low flag nibble stays zero
  assert property (@(posedge clk) disable iff (!rst_n) f_r[3:0] == 4'h0)
    else $error("low flag bits set");

endmodule
`default_nettype wire
